FILE: rtl/adcseg_pkg.sv
// Shared widths, register codes, sideband type and digit segment table for the ADC display block.
package adcseg_pkg;

	// Stream payload
	localparam int SAMPLE_W    = 10;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 48;

	// Calibration and temperature widths
	localparam int VOLT_W = 9;
	localparam int TEMP_W = 15;
	localparam int FULL_SCALE_CV = 500;

	// |v - volt_low| * |temp_high - temp_low| stays below 2**24
	localparam int PROD_W     = 24;
	localparam int DIV_STAGES = 6;
	localparam int DIV_STEPS  = PROD_W / DIV_STAGES;
	localparam int SUM_W      = 26;

	localparam int TEMP_MIN = -999;
	localparam int TEMP_MAX = 9999;

	// Decimal conversion
	localparam int MAG_W      = 14;
	localparam int BCD_DIGITS = 4;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int BCD_STAGES = 2;
	localparam int BCD_STEPS  = MAG_W / BCD_STAGES;

	// Display
	localparam int SEG_W   = 8;
	localparam int OUT_POS = 4;
	localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
	localparam logic [SEG_W-1:0] SEG_POINT = 8'h01;
	localparam logic [SEG_W-1:0] SEG_MINUS = 8'h02;

	// Register file
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 2;
	localparam logic [REG_IDX_W-1:0] REG_VOLT_LOW  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_VOLT_HIGH = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_TEMP_LOW  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_TEMP_HIGH = 2'd3;

	// Fields riding alongside the decimal conversion
	typedef struct packed {
		logic                     neg;
		logic                     flag;
		logic signed [TEMP_W-1:0] temp;
	} side_t;

	function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
		logic [SEG_W-1:0] code;
		unique case (digit)
			4'd0:    code = 8'hFC;
			4'd1:    code = 8'h60;
			4'd2:    code = 8'hDA;
			4'd3:    code = 8'hF2;
			4'd4:    code = 8'h66;
			4'd5:    code = 8'hB6;
			4'd6:    code = 8'hBE;
			4'd7:    code = 8'hE0;
			4'd8:    code = 8'hFE;
			4'd9:    code = 8'hF6;
			default: code = SEG_BLANK;
		endcase
		return code;
	endfunction

endpackage

FILE: rtl/adcseg_div.sv
// Pipelined restoring divider, unsigned magnitude by calibration voltage span.
module adcseg_div (
	input  logic                                clk,
	input  logic [adcseg_pkg::DIV_STAGES-1:0]   en,
	input  logic [adcseg_pkg::PROD_W-1:0]       dividend,
	input  logic                                neg_in,
	input  logic [adcseg_pkg::VOLT_W-1:0]       divisor,
	output logic [adcseg_pkg::PROD_W-1:0]       quotient,
	output logic                                neg_out
);
	import adcseg_pkg::*;

	logic [VOLT_W-1:0] rem_s  [DIV_STAGES];
	logic [PROD_W-1:0] work_s [DIV_STAGES];
	logic              neg_s  [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [VOLT_W-1:0] rem_in;
		logic [VOLT_W-1:0] rem_nx;
		logic [PROD_W-1:0] work_in;
		logic [PROD_W-1:0] work_nx;
		logic              neg_i;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign work_in = dividend;
			assign neg_i   = neg_in;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign work_in = work_s[k-1];
			assign neg_i   = neg_s[k-1];
		end

		// quotient bits shift in at the bottom of work as dividend bits leave the top
		always_comb begin
			logic [VOLT_W:0] trial;
			rem_nx  = rem_in;
			work_nx = work_in;
			for (int i = 0; i < DIV_STEPS; i++) begin
				trial   = {rem_nx, work_nx[PROD_W-1]};
				work_nx = {work_nx[PROD_W-2:0], 1'b0};
				if (trial >= {1'b0, divisor}) begin
					trial      = trial - {1'b0, divisor};
					work_nx[0] = 1'b1;
				end
				rem_nx = trial[VOLT_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k]  <= rem_nx;
				work_s[k] <= work_nx;
				neg_s[k]  <= neg_i;
			end
		end
	end

	assign quotient = work_s[DIV_STAGES-1];
	assign neg_out  = neg_s[DIV_STAGES-1];

endmodule

FILE: rtl/adcseg_bcd.sv
// Pipelined shift-and-add-3 binary to BCD converter with sideband.
module adcseg_bcd (
	input  logic                              clk,
	input  logic [adcseg_pkg::BCD_STAGES-1:0] en,
	input  logic [adcseg_pkg::MAG_W-1:0]      mag,
	input  adcseg_pkg::side_t                 side_in,
	output logic [adcseg_pkg::BCD_W-1:0]      bcd,
	output adcseg_pkg::side_t                 side_out
);
	import adcseg_pkg::*;

	logic [BCD_W-1:0] bcd_s  [BCD_STAGES];
	logic [MAG_W-1:0] bin_s  [BCD_STAGES];
	side_t            side_s [BCD_STAGES];

	for (genvar k = 0; k < BCD_STAGES; k++) begin : g_stage
		logic [BCD_W-1:0] bcd_in;
		logic [BCD_W-1:0] bcd_nx;
		logic [MAG_W-1:0] bin_in;
		logic [MAG_W-1:0] bin_nx;
		side_t            side_i;

		if (k == 0) begin : g_first
			assign bcd_in = '0;
			assign bin_in = mag;
			assign side_i = side_in;
		end else begin : g_next
			assign bcd_in = bcd_s[k-1];
			assign bin_in = bin_s[k-1];
			assign side_i = side_s[k-1];
		end

		always_comb begin
			bcd_nx = bcd_in;
			bin_nx = bin_in;
			for (int i = 0; i < BCD_STEPS; i++) begin
				for (int j = 0; j < BCD_DIGITS; j++) begin
					if (bcd_nx[j*4 +: 4] >= 4'd5) begin
						bcd_nx[j*4 +: 4] = bcd_nx[j*4 +: 4] + 4'd3;
					end
				end
				{bcd_nx, bin_nx} = {bcd_nx[BCD_W-2:0], bin_nx, 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				bcd_s[k]  <= bcd_nx;
				bin_s[k]  <= bin_nx;
				side_s[k] <= side_i;
			end
		end
	end

	assign bcd      = bcd_s[BCD_STAGES-1];
	assign side_out = side_s[BCD_STAGES-1];

endmodule

FILE: rtl/adcseg_seg.sv
// Right-justified seven-segment text from BCD digits and sign.
module adcseg_seg #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic [adcseg_pkg::BCD_W-1:0]                         bcd,
	input  logic                                                 neg,
	output logic [adcseg_pkg::OUT_POS-1:0][adcseg_pkg::SEG_W-1:0] chars
);
	import adcseg_pkg::*;

	// digits shown, never fewer than two: a lone digit gets a leading zero
	logic [2:0] nd;

	always_comb begin
		priority if (bcd[15:12] != 4'd0) begin
			nd = 3'd4;
		end else if (bcd[11:8] != 4'd0) begin
			nd = 3'd3;
		end else begin
			nd = 3'd2;
		end
	end

	// chars[0] is the rightmost position
	always_comb begin
		for (int k = 0; k < OUT_POS; k++) begin
			chars[k] = SEG_BLANK;
			if (k < DIGIT_COUNT) begin
				if (3'(k) < nd) begin
					chars[k] = seg_code(bcd[k*4 +: 4]);
				end else if (3'(k) == nd && neg) begin
					chars[k] = SEG_MINUS;
				end
				if (k == 1) begin
					chars[k] = chars[k] | SEG_POINT;
				end
			end
		end
	end

endmodule

FILE: rtl/adc_temperature_to_segment_display_top.sv
// Top level: ADC sample to calibrated temperature and seven-segment codes.
//
// Usage notes
// - Input stream s_axis_*: one raw ADC sample per transaction, low bits of tdata.
// - Output stream m_axis_*: one result transaction per sample, in order: four
//   segment codes (left to right), saturated temperature in tenths, range flag.
// - APB port: four calibration registers, volt_low, volt_high, temp_low,
//   temp_high at byte addresses 0, 4, 8, 12. Write them only while no sample
//   is in flight; reads return the stored bits.
// - Stages: 13 register stages (scale, multiply, six divider stages of four
//   quotient bits each, offset add, saturate, two BCD stages, segment output
//   register). Throughput: one sample per cycle when not stalled.
// - Every stage holds a valid bit and moves whenever the stage after it
//   moves or is empty, so bubbles close up.
// - Stall: with m_axis_tready low the result holds; earlier stages keep
//   filling until the pipeline is full, then s_axis_tready drops.
// - Reset (arst_n low): all valid bits clear, registers return to
//   25, 475, -500 and 1470.
module adc_temperature_to_segment_display_top #(
	parameter int DIGIT_COUNT = 4,
	parameter int SAMPLE_BITS = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// APB configuration
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [adcseg_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [adcseg_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [adcseg_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                  pready,
	// sample stream
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [adcseg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [9:0] adc_sample
	// result stream
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// [7:0] segments_left, [15:8] segments_second, [23:16] segments_third,
	// [31:24] segments_right, [46:32] temperature_tenths, [47] range_flag
	output logic [adcseg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
	import adcseg_pkg::*;

	localparam int SCALE_W    = SAMPLE_BITS + VOLT_W;
	localparam int ST_VOLT    = 0;
	localparam int ST_PROD    = 1;
	localparam int ST_DIV     = 2;
	localparam int ST_SUM     = ST_DIV + DIV_STAGES;
	localparam int ST_SAT     = ST_SUM + 1;
	localparam int ST_BCD     = ST_SAT + 1;
	localparam int ST_OUT     = ST_BCD + BCD_STAGES;
	localparam int NUM_STAGES = ST_OUT + 1;

	// ---------------------------------------------------------------
	// Calibration registers
	// ---------------------------------------------------------------
	logic [VOLT_W-1:0]        volt_low_q;
	logic [VOLT_W-1:0]        volt_high_q;
	logic signed [TEMP_W-1:0] temp_low_q;
	logic signed [TEMP_W-1:0] temp_high_q;
	logic [REG_IDX_W-1:0]     reg_idx;
	logic                     reg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign reg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_low_q  <= VOLT_W'(25);
			volt_high_q <= VOLT_W'(475);
			temp_low_q  <= TEMP_W'(-500);
			temp_high_q <= TEMP_W'(1470);
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_VOLT_LOW:  volt_low_q  <= pwdata[VOLT_W-1:0];
				REG_VOLT_HIGH: volt_high_q <= pwdata[VOLT_W-1:0];
				REG_TEMP_LOW:  temp_low_q  <= pwdata[TEMP_W-1:0];
				REG_TEMP_HIGH: temp_high_q <= pwdata[TEMP_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_VOLT_LOW:  prdata = APB_DATA_W'(volt_low_q);
			REG_VOLT_HIGH: prdata = APB_DATA_W'(volt_high_q);
			REG_TEMP_LOW:  prdata = APB_DATA_W'(unsigned'(temp_low_q));
			REG_TEMP_HIGH: prdata = APB_DATA_W'(unsigned'(temp_high_q));
		endcase
	end

	// user must keep span static with samples in flight (unchecked); later stages read it live
	logic             span_ok;
	logic [VOLT_W-1:0] span;

	assign span_ok = volt_high_q > volt_low_q;
	assign span    = volt_high_q - volt_low_q;

	// ---------------------------------------------------------------
	// Pipeline handshake: a stage loads when it is empty or its successor loads
	// ---------------------------------------------------------------
	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] vld_nx;
	logic [NUM_STAGES-1:0] en;

	always_comb begin
		en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] | m_axis_tready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] | en[k+1];
		end
	end

	assign vld_nx        = {vld_q[NUM_STAGES-2:0], s_axis_tvalid};
	assign s_axis_tready = en[ST_VOLT];
	assign m_axis_tvalid = vld_q[ST_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_nx[k];
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: sample to hundredths of a volt
	// ---------------------------------------------------------------
	logic [SAMPLE_BITS-1:0] sample_c;
	logic [SCALE_W-1:0]     scaled_c;
	logic [VOLT_W-1:0]      volt_s1;

	assign sample_c = SAMPLE_BITS'(s_axis_tdata[SAMPLE_W-1:0]);
	assign scaled_c = SCALE_W'(sample_c) * SCALE_W'(FULL_SCALE_CV);

	always_ff @(posedge clk) begin
		if (en[ST_VOLT]) begin
			volt_s1 <= VOLT_W'(scaled_c >> SAMPLE_BITS);
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: sign and magnitude of (v - volt_low) * (temp_high - temp_low)
	// ---------------------------------------------------------------
	logic signed [VOLT_W+1:0] dv_c;
	logic [VOLT_W+1:0]        dv_abs;
	logic signed [TEMP_W:0]   dt_c;
	logic [TEMP_W:0]          dt_abs;
	logic [PROD_W-1:0]        prod_s2;
	logic                     neg_s2;

	assign dv_c   = signed'({2'b00, volt_s1}) - signed'({2'b00, volt_low_q});
	assign dv_abs = dv_c[VOLT_W+1] ? unsigned'(-dv_c) : unsigned'(dv_c);
	assign dt_c   = (TEMP_W+1)'(temp_high_q) - (TEMP_W+1)'(temp_low_q);
	assign dt_abs = dt_c[TEMP_W] ? unsigned'(-dt_c) : unsigned'(dt_c);

	always_ff @(posedge clk) begin
		if (en[ST_PROD]) begin
			prod_s2 <= PROD_W'(dv_abs[VOLT_W-1:0]) * PROD_W'(dt_abs[TEMP_W-1:0]);
			neg_s2  <= dv_c[VOLT_W+1] ^ dt_c[TEMP_W];
		end
	end

	// ---------------------------------------------------------------
	// Stages 3..8: magnitude / span, truncating
	// ---------------------------------------------------------------
	logic [PROD_W-1:0] quo_c;
	logic              quo_neg;

	adcseg_div u_div (
		.clk      (clk),
		.en       (en[ST_DIV +: DIV_STAGES]),
		.dividend (prod_s2),
		.neg_in   (neg_s2),
		.divisor  (span),
		.quotient (quo_c),
		.neg_out  (quo_neg)
	);

	// ---------------------------------------------------------------
	// Stage 9: add the lower temperature point
	// ---------------------------------------------------------------
	logic signed [SUM_W-1:0] quo_sx;
	logic signed [SUM_W-1:0] tlow_sx;
	logic signed [SUM_W-1:0] sum_s9;
	logic                    flag_s9;

	assign quo_sx  = signed'({2'b00, quo_c});
	assign tlow_sx = SUM_W'(temp_low_q);

	always_ff @(posedge clk) begin
		if (en[ST_SUM]) begin
			if (!span_ok) begin
				sum_s9 <= tlow_sx;
			end else if (quo_neg) begin
				sum_s9 <= tlow_sx - quo_sx;
			end else begin
				sum_s9 <= tlow_sx + quo_sx;
			end
			flag_s9 <= !span_ok;
		end
	end

	// ---------------------------------------------------------------
	// Stage 10: saturate, split sign and magnitude
	// ---------------------------------------------------------------
	logic                    sat_lo;
	logic                    sat_hi;
	logic signed [SUM_W-1:0] sum_abs;
	logic [MAG_W-1:0]        mag_c;
	side_t                   side_c;
	logic [MAG_W-1:0]        mag_s10;
	side_t                   side_s10;

	assign sat_lo  = sum_s9 < SUM_W'(TEMP_MIN);
	assign sat_hi  = sum_s9 > SUM_W'(TEMP_MAX);
	assign sum_abs = sum_s9[SUM_W-1] ? -sum_s9 : sum_s9;

	always_comb begin
		priority if (sat_lo) begin
			mag_c       = MAG_W'(-TEMP_MIN);
			side_c.temp = TEMP_W'(TEMP_MIN);
		end else if (sat_hi) begin
			mag_c       = MAG_W'(TEMP_MAX);
			side_c.temp = TEMP_W'(TEMP_MAX);
		end else begin
			mag_c       = sum_abs[MAG_W-1:0];
			side_c.temp = sum_s9[TEMP_W-1:0];
		end
		side_c.neg  = sum_s9[SUM_W-1];
		side_c.flag = flag_s9 | sat_lo | sat_hi;
	end

	always_ff @(posedge clk) begin
		if (en[ST_SAT]) begin
			mag_s10  <= mag_c;
			side_s10 <= side_c;
		end
	end

	// ---------------------------------------------------------------
	// Stages 11..12: decimal digits
	// ---------------------------------------------------------------
	logic [BCD_W-1:0] bcd_c;
	side_t            side_bcd;

	adcseg_bcd u_bcd (
		.clk      (clk),
		.en       (en[ST_BCD +: BCD_STAGES]),
		.mag      (mag_s10),
		.side_in  (side_s10),
		.bcd      (bcd_c),
		.side_out (side_bcd)
	);

	// ---------------------------------------------------------------
	// Stage 13: segment codes, output register
	// ---------------------------------------------------------------
	logic [OUT_POS-1:0][SEG_W-1:0] chars_c;
	logic [OUT_POS-1:0][SEG_W-1:0] segs_s13;
	logic signed [TEMP_W-1:0]      temp_s13;
	logic                          flag_s13;

	adcseg_seg #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_seg (
		.bcd   (bcd_c),
		.neg   (side_bcd.neg),
		.chars (chars_c)
	);

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			segs_s13 <= chars_c;
			temp_s13 <= side_bcd.temp;
			flag_s13 <= side_bcd.flag;
		end
	end

	// segs_s13[0] is the rightmost position
	assign m_axis_tdata = {flag_s13, temp_s13,
	                       segs_s13[0], segs_s13[1], segs_s13[2], segs_s13[3]};

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> vld_q[ST_VOLT])
		else $error("accepted sample did not enter the pipeline");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((($past(vld_q) & ~$past(en)) & ~vld_q) == '0))
		else $error("stalled stage lost its item");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (temp_s13 >= TEMP_W'(TEMP_MIN)) && (temp_s13 <= TEMP_W'(TEMP_MAX)))
		else $error("temperature outside saturation limits");

	a_point: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> segs_s13[1][0])
		else $error("decimal point missing on tenths position");

	a_tenths_digit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (segs_s13[0] != SEG_BLANK) && !segs_s13[0][0])
		else $error("rightmost position is not a plain digit");

endmodule
